FILE: hdl/mrtu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus RTU responder package
// Shared transaction types, function codes, register indexes and CRC constants.
// ----------------------------------------------------------------------------
package mrtu_pkg;

  typedef struct packed {
    logic [7:0]  station;
    logic [7:0]  opcode;
    logic [15:0] register_address;
    logic [15:0] data_word;
    logic [15:0] crc_received;
    logic [15:0] fault_flags;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  tx_byte;
    logic        last_byte;
    logic [15:0] drive_frequency;
    logic [7:0]  drive_duty;
    logic        drive_enable;
  } out_item_t;

  // Function codes.
  localparam logic [7:0] OP_READ_BITS  = 8'h01;
  localparam logic [7:0] OP_READ_REGS  = 8'h03;
  localparam logic [7:0] OP_WRITE_BIT  = 8'h05;
  localparam logic [7:0] OP_WRITE_REG  = 8'h06;

  // Configuration register indexes.
  localparam logic CFG_FREQ_LIMIT = 1'b0;
  localparam logic CFG_DUTY_LIMIT = 1'b1;

  // Register addresses used by the write requests.
  localparam logic [15:0] ADDR_ENABLE = 16'd0;
  localparam logic [15:0] ADDR_FREQ   = 16'd1;
  localparam logic [15:0] ADDR_DUTY   = 16'd2;

  localparam logic [15:0] FREQ_LIMIT_RESET = 16'd10000;
  localparam logic [7:0]  DUTY_LIMIT_RESET = 8'd100;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] BYTE_COUNT_BITS = 8'h02;
  localparam logic [7:0] BYTE_COUNT_REGS = 8'h04;
  localparam logic [7:0] COIL_ON         = 8'hFF;

endpackage
`default_nettype wire

FILE: hdl/mrtu_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus RTU responder channels
// Valid/ready channels for request and reply-byte transactions.
// ----------------------------------------------------------------------------
interface mrtu_in_if;
  logic               valid;
  logic               ready;
  mrtu_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface mrtu_out_if;
  logic                valid;
  logic                ready;
  mrtu_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: hdl/modbus_rtu_slave_responder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus RTU slave responder
// Checks one 8-byte request, updates the drive settings and sends the reply.
// ----------------------------------------------------------------------------
// Usage:
// A complete request is offered on in_chan as one transaction carrying the
// decoded fields of the frame plus the present fault flags. The block is ready
// only when idle. It recomputes the CRC-16 over the first six request bytes
// with a bit-serial CRC unit, one bit per cycle. A request with a bad CRC or
// an unknown function code is dropped silently. Read requests build a reply
// whose CRC is computed by the same unit; write requests are applied and
// echoed. Reply bytes leave on out_chan, one per transaction, with last_byte
// set on the final one and the drive settings after the request attached to
// every byte. A stall on out_chan simply holds the current byte. The limits
// are to be written through the cfg_ port only while idle; the block itself
// does not enforce this. Reset (rst_n low, synchronous) returns to idle,
// clears the settings and restores the limits to 10000 and 100.
// ----------------------------------------------------------------------------
module modbus_rtu_slave_responder import mrtu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  mrtu_in_if.sink          in_chan,
  mrtu_out_if.source       out_chan,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CRC    = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_STORE  = 3'd3;
  localparam logic [2:0] ST_SEND   = 3'd4;

  localparam int BufDepth = 9;

  logic [2:0]  state_r, state_nxt;
  logic        pass_reply_r, pass_reply_nxt;   // CRC pass over the reply, not the request
  logic [3:0]  byte_idx_r, byte_idx_nxt;
  logic [2:0]  bit_idx_r, bit_idx_nxt;
  logic [3:0]  crc_len_r, crc_len_nxt;
  logic [3:0]  len_r, len_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [2:0]  fault_r, fault_nxt;

  logic [15:0] freq_limit_r, freq_limit_nxt;
  logic [7:0]  duty_limit_r, duty_limit_nxt;
  logic        enable_r, enable_nxt;
  logic [15:0] freq_set_r, freq_set_nxt;
  logic [7:0]  duty_set_r, duty_set_nxt;

  logic [7:0]  rep_buf_r   [BufDepth];
  logic [7:0]  rep_buf_nxt [BufDepth];

  logic [7:0]  cur_byte;
  logic        crc_fb;
  logic [15:0] crc_step;
  logic        out_fire;
  logic        in_fire;
  logic        is_last;
  logic [7:0]  opcode;
  logic [15:0] req_addr;
  logic [15:0] req_data;
  logic        crc_ok;

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign out_chan.valid = (state_r == ST_SEND);
  assign out_fire       = out_chan.valid && out_chan.ready;
  assign is_last        = (byte_idx_r == len_r - 4'd1);

  assign out_chan.payload.tx_byte         = rep_buf_r[byte_idx_r];
  assign out_chan.payload.last_byte       = is_last;
  assign out_chan.payload.drive_frequency = freq_set_r;
  assign out_chan.payload.drive_duty      = duty_set_r;
  assign out_chan.payload.drive_enable    = enable_r;

  // The shared CRC unit: one message bit per cycle, least significant first.
  // Feeding bits one at a time is equivalent to xoring a whole byte in and
  // shifting eight times.
  assign cur_byte = rep_buf_r[byte_idx_r];
  assign crc_fb   = crc_r[0] ^ cur_byte[bit_idx_r];
  assign crc_step = {1'b0, crc_r[15:1]} ^ (crc_fb ? CRC_POLY : 16'h0000);

  assign opcode   = rep_buf_r[1];
  assign req_addr = {rep_buf_r[2], rep_buf_r[3]};
  assign req_data = {rep_buf_r[4], rep_buf_r[5]};
  assign crc_ok   = (crc_r == {rep_buf_r[7], rep_buf_r[6]});

  always_comb begin
    state_nxt      = state_r;
    pass_reply_nxt = pass_reply_r;
    byte_idx_nxt   = byte_idx_r;
    bit_idx_nxt    = bit_idx_r;
    crc_len_nxt    = crc_len_r;
    len_nxt        = len_r;
    crc_nxt        = crc_r;
    fault_nxt      = fault_r;
    freq_limit_nxt = freq_limit_r;
    duty_limit_nxt = duty_limit_r;
    enable_nxt     = enable_r;
    freq_set_nxt   = freq_set_r;
    duty_set_nxt   = duty_set_r;
    for (int i = 0; i < BufDepth; i++) begin
      rep_buf_nxt[i] = rep_buf_r[i];
    end

    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FREQ_LIMIT: freq_limit_nxt = cfg_wdata;
        CFG_DUTY_LIMIT: duty_limit_nxt = cfg_wdata[7:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          rep_buf_nxt[0] = in_chan.payload.station;
          rep_buf_nxt[1] = in_chan.payload.opcode;
          rep_buf_nxt[2] = in_chan.payload.register_address[15:8];
          rep_buf_nxt[3] = in_chan.payload.register_address[7:0];
          rep_buf_nxt[4] = in_chan.payload.data_word[15:8];
          rep_buf_nxt[5] = in_chan.payload.data_word[7:0];
          rep_buf_nxt[6] = in_chan.payload.crc_received[7:0];
          rep_buf_nxt[7] = in_chan.payload.crc_received[15:8];
          fault_nxt      = {in_chan.payload.fault_flags[4], in_chan.payload.fault_flags[3],
                            in_chan.payload.fault_flags[5]};
          crc_nxt        = CRC_INIT;
          byte_idx_nxt   = 4'd0;
          bit_idx_nxt    = 3'd0;
          crc_len_nxt    = 4'd6;
          pass_reply_nxt = 1'b0;
          state_nxt      = ST_CRC;
        end
      end

      ST_CRC: begin
        crc_nxt     = crc_step;
        bit_idx_nxt = bit_idx_r + 3'd1;
        if (bit_idx_r == 3'd7) begin
          byte_idx_nxt = byte_idx_r + 4'd1;
          if (byte_idx_r == crc_len_r - 4'd1) begin
            state_nxt = pass_reply_r ? ST_STORE : ST_DECIDE;
          end
        end
      end

      ST_DECIDE: begin
        byte_idx_nxt = 4'd0;
        bit_idx_nxt  = 3'd0;
        crc_nxt      = CRC_INIT;
        state_nxt    = ST_IDLE;
        if (crc_ok) begin
          case (opcode)
            OP_READ_BITS: begin
              rep_buf_nxt[2] = BYTE_COUNT_BITS;
              rep_buf_nxt[3] = {3'b000, enable_r, fault_r, enable_r};
              rep_buf_nxt[4] = 8'h00;
              crc_len_nxt    = 4'd5;
              len_nxt        = 4'd7;
              pass_reply_nxt = 1'b1;
              state_nxt      = ST_CRC;
            end
            OP_READ_REGS: begin
              rep_buf_nxt[2] = BYTE_COUNT_REGS;
              rep_buf_nxt[3] = freq_set_r[15:8];
              rep_buf_nxt[4] = freq_set_r[7:0];
              rep_buf_nxt[5] = 8'h00;
              rep_buf_nxt[6] = duty_set_r;
              crc_len_nxt    = 4'd7;
              len_nxt        = 4'd9;
              pass_reply_nxt = 1'b1;
              state_nxt      = ST_CRC;
            end
            OP_WRITE_BIT: begin
              if (req_addr == ADDR_ENABLE) begin
                enable_nxt = (rep_buf_r[4] == COIL_ON);
              end
              len_nxt   = 4'd8;
              state_nxt = ST_SEND;
            end
            OP_WRITE_REG: begin
              if (req_addr == ADDR_FREQ) begin
                freq_set_nxt = (req_data > freq_limit_r) ? freq_limit_r : req_data;
              end else if (req_addr == ADDR_DUTY) begin
                duty_set_nxt = (rep_buf_r[5] > duty_limit_r) ? duty_limit_r : rep_buf_r[5];
              end
              len_nxt   = 4'd8;
              state_nxt = ST_SEND;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end

      ST_STORE: begin
        // Append the reply CRC, low byte first, after the last covered byte.
        rep_buf_nxt[crc_len_r]        = crc_r[7:0];
        rep_buf_nxt[crc_len_r + 4'd1] = crc_r[15:8];
        byte_idx_nxt                  = 4'd0;
        state_nxt                     = ST_SEND;
      end

      ST_SEND: begin
        if (out_fire) begin
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            byte_idx_nxt = byte_idx_r + 4'd1;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pass_reply_r <= 1'b0;
      byte_idx_r   <= 4'd0;
      bit_idx_r    <= 3'd0;
      crc_len_r    <= 4'd6;
      len_r        <= 4'd8;
      freq_limit_r <= FREQ_LIMIT_RESET;
      duty_limit_r <= DUTY_LIMIT_RESET;
      enable_r     <= 1'b0;
      freq_set_r   <= 16'd0;
      duty_set_r   <= 8'd0;
    end else begin
      state_r      <= state_nxt;
      pass_reply_r <= pass_reply_nxt;
      byte_idx_r   <= byte_idx_nxt;
      bit_idx_r    <= bit_idx_nxt;
      crc_len_r    <= crc_len_nxt;
      len_r        <= len_nxt;
      freq_limit_r <= freq_limit_nxt;
      duty_limit_r <= duty_limit_nxt;
      enable_r     <= enable_nxt;
      freq_set_r   <= freq_set_nxt;
      duty_set_r   <= duty_set_nxt;
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk) begin
    crc_r   <= crc_nxt;
    fault_r <= fault_nxt;
    for (int i = 0; i < BufDepth; i++) begin
      rep_buf_r[i] <= rep_buf_nxt[i];
    end
  end

`ifndef SYNTHESIS
  // The settings only move when a request is acted upon.
  a_settings_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_DECIDE) |=> ($stable(freq_set_r) && $stable(duty_set_r) && $stable(enable_r)))
    else $error("drive settings changed outside the decision step");

  // A reply is always seven, eight or nine bytes long.
  a_reply_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEND) |-> ((len_r == 4'd7) || (len_r == 4'd8) || (len_r == 4'd9)))
    else $error("reply length out of range");

  // The byte pointer never runs past the end of the reply.
  a_send_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEND) |-> (byte_idx_r < len_r))
    else $error("reply byte pointer beyond reply length");

  // After the final reply byte the block takes a new request at once.
  a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && is_last) |=> in_chan.ready)
    else $error("not ready after the final reply byte");

  // A request is never taken while a reply byte is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_fire && out_chan.valid))
    else $error("request accepted during a reply");
`endif

endmodule
`default_nettype wire
